// File: hw/rtl/amru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amru_pkg
// Shared types and constants of the atomic read-modify-write unit.
// ----------------------------------------------------------------------------
package amru_pkg;

	localparam int unsigned MEM_WORDS_DEF = 1024;
	localparam int unsigned ADDR_W        = 10;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned MODE_W        = 4;
	localparam int unsigned IN_TDATA_W    = 80;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_ADD  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_FADD = 4'd1;
	localparam logic [MODE_W-1:0] MODE_EXCH = 4'd2;
	localparam logic [MODE_W-1:0] MODE_SMIN = 4'd3;
	localparam logic [MODE_W-1:0] MODE_UMIN = 4'd4;
	localparam logic [MODE_W-1:0] MODE_SMAX = 4'd5;
	localparam logic [MODE_W-1:0] MODE_UMAX = 4'd6;
	localparam logic [MODE_W-1:0] MODE_INC  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_DEC  = 4'd8;
	localparam logic [MODE_W-1:0] MODE_CAS  = 4'd9;
	localparam logic [MODE_W-1:0] MODE_AND  = 4'd10;
	localparam logic [MODE_W-1:0] MODE_OR   = 4'd11;
	localparam logic [MODE_W-1:0] MODE_XOR  = 4'd12;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_READ,
		ST_CALC,
		ST_FA_ALIGN,
		ST_FA_ADD,
		ST_FA_NORM,
		ST_FA_ROUND,
		ST_WRITE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic wrap;
		logic rd;
		logic calc;
		logic fa_align;
		logic fa_add;
		logic fa_norm;
		logic fa_round;
		logic wr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic addr_big;
		logic is_fadd;
		logic fa_special;
		logic fa_zero;
		logic norm_done;
		logic out_free;
	} status_t;

endpackage

// File: hw/rtl/atomic_memory_rmw_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atomic_memory_rmw_unit
// Atomic read-modify-write unit in front of a word memory of MEM_WORDS words.
// ----------------------------------------------------------------------------
// Usage:
//  - the s_ channel takes one request item {mode, address, operand, new_value};
//    the m_ channel returns one item per request: the word before the update
//  - items are handled one at a time by a sequencer; s_tready is high only
//    while the unit is free
//  - integer ops and float special cases: accept, wrap, read, compute, write;
//    the wrap step repeats, one subtraction each, while the address is >= MEM_WORDS
//  - float add: compute, align, add, normalize one bit at a time after
//    cancellation, round, write; add goes straight to write when the sum cancels to zero
//  - the next item is accepted in the cycle after the write, so the unit takes no
//    new item before the last one is written
//  - a finished item waits in the output register; while it waits the unit
//    accepts and works on the next item, stalling only at its write step
//  - reset clears control state; memory contents stay undefined until written
// ----------------------------------------------------------------------------
module atomic_memory_rmw_unit #(
	parameter int unsigned MEM_WORDS = amru_pkg::MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // mode[3:0], address[13:4], operand[45:14], new_value[77:46]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // old_value[31:0]
);

	amru_pkg::cmd_t    cmd;
	amru_pkg::status_t sts;

	amru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	amru_dp #(
		.MEM_WORDS (MEM_WORDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_mode       (s_tdata[3:0]),
		.in_address    (s_tdata[13:4]),
		.in_operand    (s_tdata[45:14]),
		.in_new_value  (s_tdata[77:46]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_old_value (m_tdata)
	);

	// one item in flight: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second item while busy");

	// a result appears only after a memory write
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.wr))
		else $error("result without write");

	// write never overruns a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (!m_tvalid || m_tready))
		else $error("write while output full");

endmodule

// File: hw/rtl/amru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amru_ctrl
// Sequencer of the unit: steps one item through wrap, read, compute, the float add steps when needed, write.
// ----------------------------------------------------------------------------
module amru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  amru_pkg::status_t sts,
	output amru_pkg::cmd_t    cmd
);

	amru_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			amru_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = amru_pkg::ST_WRAP;
				end
			end
			amru_pkg::ST_WRAP: begin
				if (sts.addr_big) begin
					cmd.wrap = 1'b1;
				end else begin
					state_d = amru_pkg::ST_READ;
				end
			end
			amru_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = amru_pkg::ST_CALC;
			end
			amru_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				if (sts.is_fadd && !sts.fa_special) begin
					state_d = amru_pkg::ST_FA_ALIGN;
				end else begin
					state_d = amru_pkg::ST_WRITE;
				end
			end
			amru_pkg::ST_FA_ALIGN: begin
				cmd.fa_align = 1'b1;
				state_d      = amru_pkg::ST_FA_ADD;
			end
			amru_pkg::ST_FA_ADD: begin
				cmd.fa_add = 1'b1;
				state_d    = sts.fa_zero ? amru_pkg::ST_WRITE : amru_pkg::ST_FA_NORM;
			end
			amru_pkg::ST_FA_NORM: begin
				if (sts.norm_done) begin
					state_d = amru_pkg::ST_FA_ROUND;
				end else begin
					cmd.fa_norm = 1'b1;
				end
			end
			amru_pkg::ST_FA_ROUND: begin
				cmd.fa_round = 1'b1;
				state_d      = amru_pkg::ST_WRITE;
			end
			amru_pkg::ST_WRITE: begin
				if (sts.out_free) begin
					cmd.wr  = 1'b1;
					state_d = amru_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = amru_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/amru_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amru_dp
// Datapath: request registers, word memory, integer ops, staged float adder
// and the output register.
// ----------------------------------------------------------------------------
module amru_dp #(
	parameter int unsigned MEM_WORDS = amru_pkg::MEM_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  amru_pkg::cmd_t                  cmd,
	output amru_pkg::status_t               sts,
	input  logic [amru_pkg::MODE_W-1:0]     in_mode,
	input  logic [amru_pkg::ADDR_W-1:0]     in_address,
	input  logic [amru_pkg::WORD_W-1:0]     in_operand,
	input  logic [amru_pkg::WORD_W-1:0]     in_new_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [amru_pkg::WORD_W-1:0]     out_old_value
);

	localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	logic [amru_pkg::MODE_W-1:0] mode_q;
	logic [amru_pkg::ADDR_W-1:0] addr_q;
	logic [31:0]                 op_q, nv_q, rdata_q, res_q, oldv_q;
	logic [31:0]                 mem_q [MEM_WORDS];
	logic                        ovalid_q;

	// float adder working registers
	logic        fsign_q, fsub_q;
	logic [7:0]  fd_q;
	logic [8:0]  fe_q;
	logic [26:0] fma_q, fmb_q;
	logic [27:0] fm_q;

	logic [AW-1:0] idx;
	assign idx = AW'(addr_q);

	// address wrap, one subtraction per cycle
	assign sts.addr_big = {7'd0, addr_q} >= 17'(MEM_WORDS);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			addr_q <= in_address;
			op_q   <= in_operand;
			nv_q   <= in_new_value;
		end else if (cmd.wrap) begin
			addr_q <= addr_q - amru_pkg::ADDR_W'(MEM_WORDS);
		end
	end

	// word memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem_q[idx];
		end
		if (cmd.wr) begin
			mem_q[idx] <= res_q;
		end
	end

	// float special cases and unpacking
	logic [31:0] fa_a, fa_b, fa_aa, fa_ab, fa_spec_res;
	logic        a_nan, b_nan, a_inf, b_inf, swap;
	logic [7:0]  ea, eb;
	logic [26:0] ma, mb;

	always_comb begin
		a_nan = (rdata_q & 32'h7FFF_FFFF) > 32'h7F80_0000;
		b_nan = (op_q & 32'h7FFF_FFFF) > 32'h7F80_0000;
		a_inf = (rdata_q & 32'h7FFF_FFFF) == 32'h7F80_0000;
		b_inf = (op_q & 32'h7FFF_FFFF) == 32'h7F80_0000;
		if (a_nan) begin
			fa_spec_res = rdata_q | 32'h0040_0000;
		end else if (b_nan) begin
			fa_spec_res = op_q | 32'h0040_0000;
		end else if (a_inf && b_inf && (rdata_q[31] ^ op_q[31])) begin
			fa_spec_res = 32'h7FC0_0000;
		end else begin
			fa_spec_res = a_inf ? rdata_q : op_q;
		end
		swap  = (op_q & 32'h7FFF_FFFF) > (rdata_q & 32'h7FFF_FFFF);
		fa_a  = swap ? op_q : rdata_q;
		fa_b  = swap ? rdata_q : op_q;
		fa_aa = fa_a & 32'h7FFF_FFFF;
		fa_ab = fa_b & 32'h7FFF_FFFF;
		ea    = (fa_aa[30:23] == 8'd0) ? 8'd1 : fa_aa[30:23];
		eb    = (fa_ab[30:23] == 8'd0) ? 8'd1 : fa_ab[30:23];
		ma    = {(fa_aa[30:23] != 8'd0), fa_aa[22:0], 3'b000};
		mb    = {(fa_ab[30:23] != 8'd0), fa_ab[22:0], 3'b000};
	end
	assign sts.fa_special = a_nan || b_nan || a_inf || b_inf;

	// integer ops and the float special-case result
	logic [31:0] int_res;
	always_comb begin
		case (mode_q)
			amru_pkg::MODE_ADD:  int_res = rdata_q + op_q;
			amru_pkg::MODE_FADD: int_res = fa_spec_res;
			amru_pkg::MODE_EXCH: int_res = op_q;
			amru_pkg::MODE_SMIN: int_res = ($signed(rdata_q) <= $signed(op_q)) ? rdata_q : op_q;
			amru_pkg::MODE_UMIN: int_res = (rdata_q <= op_q) ? rdata_q : op_q;
			amru_pkg::MODE_SMAX: int_res = ($signed(rdata_q) >= $signed(op_q)) ? rdata_q : op_q;
			amru_pkg::MODE_UMAX: int_res = (rdata_q >= op_q) ? rdata_q : op_q;
			amru_pkg::MODE_INC:  int_res = (rdata_q >= op_q) ? 32'd0 : rdata_q + 32'd1;
			amru_pkg::MODE_DEC:  int_res = (rdata_q == 32'd0 || rdata_q > op_q) ? op_q
			                               : rdata_q - 32'd1;
			amru_pkg::MODE_CAS:  int_res = (rdata_q == op_q) ? nv_q : rdata_q;
			amru_pkg::MODE_AND:  int_res = rdata_q & op_q;
			amru_pkg::MODE_OR:   int_res = rdata_q | op_q;
			amru_pkg::MODE_XOR:  int_res = rdata_q ^ op_q;
			default:             int_res = rdata_q;
		endcase
	end
	assign sts.is_fadd = (mode_q == amru_pkg::MODE_FADD);

	// alignment of the smaller operand with sticky bit
	logic [26:0] mb_al, lost_mask;
	always_comb begin
		lost_mask = ~(27'h7FF_FFFF << fd_q[4:0]);
		if (fd_q >= 8'd27) begin
			mb_al = {26'd0, (fmb_q != 27'd0)};
		end else begin
			mb_al = (fmb_q >> fd_q[4:0]) | {26'd0, ((fmb_q & lost_mask) != 27'd0)};
		end
	end

	// add or subtract magnitudes
	logic [27:0] sum_raw;
	assign sum_raw     = fsub_q ? ({1'b0, fma_q} - {1'b0, fmb_q})
	                            : ({1'b0, fma_q} + {1'b0, fmb_q});
	assign sts.fa_zero = fsub_q && (sum_raw == 28'd0);

	// normalize one bit per cycle
	assign sts.norm_done = (fm_q[27:26] != 2'b00) || (fe_q <= 9'd1);

	// rounding to nearest even and packing
	logic [24:0] rm;
	logic [8:0]  re;
	logic [31:0] fa_res;
	always_comb begin
		rm = fm_q[27:3];
		if (fm_q[2:0] > 3'd4 || (fm_q[2:0] == 3'd4 && fm_q[3])) begin
			rm = rm + 25'd1;
		end
		re = fe_q;
		if (rm[24]) begin
			rm = rm >> 1;
			re = re + 9'd1;
		end
		if (re >= 9'd255) begin
			fa_res = {fsign_q, 31'h7F80_0000};
		end else begin
			fa_res = {fsign_q, (rm[23] ? re[7:0] : 8'd0), rm[22:0]};
		end
	end

	// float adder stage registers and result
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			res_q   <= int_res;
			fsign_q <= fa_a[31];
			fsub_q  <= fa_a[31] ^ fa_b[31];
			fd_q    <= ea - eb;
			fe_q    <= {1'b0, ea};
			fma_q   <= ma;
			fmb_q   <= mb;
		end
		if (cmd.fa_align) begin
			fmb_q <= mb_al;
		end
		if (cmd.fa_add) begin
			if (sts.fa_zero) begin
				res_q <= 32'd0;
			end else if (!fsub_q && sum_raw[27]) begin
				fm_q <= {1'b0, sum_raw[27:1]} | {27'd0, sum_raw[0]};
				fe_q <= fe_q + 9'd1;
			end else begin
				fm_q <= sum_raw;
			end
		end
		if (cmd.fa_norm) begin
			fm_q <= fm_q << 1;
			fe_q <= fe_q - 9'd1;
		end
		if (cmd.fa_round) begin
			res_q <= fa_res;
		end
	end

	// output register
	assign sts.out_free = !ovalid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.wr) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			oldv_q <= rdata_q;
		end
	end

	assign out_valid     = ovalid_q;
	assign out_old_value = oldv_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the atomic read-modify-write unit: every request's
// returned old word is predicted from a shadow copy of the memory, with
// directed corner cases followed by random traffic under random flow control.
// ----------------------------------------------------------------------------
module testbench;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // mode[3:0], address[13:4], operand[45:14], new_value[77:46]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // old_value[31:0]

	// shadow memory and a mask of words written so far
	logic [31:0] shadow_mem [amru_pkg::MEM_WORDS_DEF];
	bit          written [amru_pkg::MEM_WORDS_DEF];
	logic [31:0] old_word_q [$];
	// whether the expected old word is known (the word was written before)
	bit          known_q [$];

	int errors;
	int sent_count;
	int got_count;
	int idle_cycles;
	bit stall_on;
	bit test_done;

	atomic_memory_rmw_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// single-precision add, round to nearest even, subnormals kept
	function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma32, mb32, t, sgn;
		logic [63:0] ma, mb, m, lost;
		int          ea, eb, d, e;
		bit          sub;
		logic [2:0]  g;
		ma32 = a & 32'h7FFF_FFFF;
		mb32 = b & 32'h7FFF_FFFF;
		if (ma32 > 32'h7F80_0000) return a | 32'h0040_0000;
		if (mb32 > 32'h7F80_0000) return b | 32'h0040_0000;
		if (ma32 == 32'h7F80_0000 || mb32 == 32'h7F80_0000) begin
			if (ma32 == 32'h7F80_0000 && mb32 == 32'h7F80_0000 && (a[31] ^ b[31]))
				return 32'h7FC0_0000;
			return (ma32 == 32'h7F80_0000) ? a : b;
		end
		if (mb32 > ma32) begin
			t = a; a = b; b = t;
			t = ma32; ma32 = mb32; mb32 = t;
		end
		sgn = a & 32'h8000_0000;
		sub = a[31] ^ b[31];
		ea = ma32[30:23];
		eb = mb32[30:23];
		ma = {41'd0, ma32[22:0]};
		mb = {41'd0, mb32[22:0]};
		if (ea == 0) ea = 1; else ma[23] = 1'b1;
		if (eb == 0) eb = 1; else mb[23] = 1'b1;
		ma = ma << 3;
		mb = mb << 3;
		d = ea - eb;
		if (d > 40) begin
			mb = (mb != 0) ? 64'd1 : 64'd0;
		end else if (d > 0) begin
			lost = mb & ((64'd1 << d) - 64'd1);
			mb = (mb >> d) | ((lost != 0) ? 64'd1 : 64'd0);
		end
		e = ea;
		if (!sub) begin
			m = ma + mb;
			if (m >= (64'd1 << 27)) begin
				m = (m >> 1) | (m & 64'd1);
				e++;
			end
		end else begin
			m = ma - mb;
			if (m == 0) return 32'd0;
		end
		while (m < (64'd1 << 26) && e > 1) begin
			m = m << 1;
			e--;
		end
		g = m[2:0];
		m = m >> 3;
		if (g > 3'd4 || (g == 3'd4 && m[0])) m++;
		if (m >= (64'd1 << 24)) begin
			m = m >> 1;
			e++;
		end
		if (e >= 255) return sgn | 32'h7F80_0000;
		return sgn | ((m < (64'd1 << 23)) ? 32'd0 : (32'(e) << 23)) | m[22:0];
	endfunction

	// new word that a request leaves behind
	function automatic logic [31:0] updated_word(logic [3:0] mode, logic [31:0] old,
			logic [31:0] opnd, logic [31:0] nval);
		case (mode)
			amru_pkg::MODE_ADD:  return old + opnd;
			amru_pkg::MODE_FADD: return float_sum(old, opnd);
			amru_pkg::MODE_EXCH: return opnd;
			amru_pkg::MODE_SMIN: return ($signed(old) <= $signed(opnd)) ? old : opnd;
			amru_pkg::MODE_UMIN: return (old <= opnd) ? old : opnd;
			amru_pkg::MODE_SMAX: return ($signed(old) >= $signed(opnd)) ? old : opnd;
			amru_pkg::MODE_UMAX: return (old >= opnd) ? old : opnd;
			amru_pkg::MODE_INC:  return (old >= opnd) ? 32'd0 : old + 32'd1;
			amru_pkg::MODE_DEC:  return (old == 0 || old > opnd) ? opnd : old - 32'd1;
			amru_pkg::MODE_CAS:  return (old == opnd) ? nval : old;
			amru_pkg::MODE_AND:  return old & opnd;
			amru_pkg::MODE_OR:   return old | opnd;
			amru_pkg::MODE_XOR:  return old ^ opnd;
			default:             return old;
		endcase
	endfunction

	// drive one request item; predicts its result at acceptance
	task automatic send_request(logic [3:0] mode, logic [9:0] addr, logic [31:0] opnd,
			logic [31:0] nval);
		logic [31:0] old;
		s_tdata  <= {2'b00, nval, opnd, addr, mode};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		old = shadow_mem[addr];
		old_word_q.push_back(old);
		known_q.push_back(written[addr]);
		shadow_mem[addr] = updated_word(mode, old, opnd, nval);
		written[addr] = 1'b1;
		sent_count++;
		@(negedge clk);
	endtask

	task automatic pause_sender(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (old_word_q.size() != 0) @(negedge clk);
	endtask

	// seed every word not yet written with an exchange; a fresh word's old value is not checked
	task automatic test_seed_memory();
		logic [31:0] junk;
		for (int i = 0; i < amru_pkg::MEM_WORDS_DEF; i++) begin
			junk = $urandom;
			if (!written[i]) begin
				shadow_mem[i] = 32'd0;
				send_request(amru_pkg::MODE_EXCH, 10'(i), junk, $urandom);
			end
		end
	endtask

	task automatic test_directed();
		// integer extremes
		send_request(amru_pkg::MODE_EXCH, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(amru_pkg::MODE_ADD,  10'd0, 32'd1, 32'd0);
		send_request(amru_pkg::MODE_SMIN, 10'd0, 32'h8000_0000, 32'd0);
		send_request(amru_pkg::MODE_SMAX, 10'd0, 32'h7FFF_FFFF, 32'd0);
		send_request(amru_pkg::MODE_UMIN, 10'd0, 32'd0, 32'd0);
		send_request(amru_pkg::MODE_UMAX, 10'd0, 32'hFFFF_FFFF, 32'd0);
		send_request(amru_pkg::MODE_INC,  10'd0, 32'hFFFF_FFFF, 32'd0);
		send_request(amru_pkg::MODE_INC,  10'd0, 32'd0, 32'd0);
		send_request(amru_pkg::MODE_DEC,  10'd0, 32'd5, 32'd0);
		send_request(amru_pkg::MODE_DEC,  10'd0, 32'd3, 32'd0);
		send_request(amru_pkg::MODE_CAS,  10'd0, 32'd4, 32'hA5A5_5A5A);
		send_request(amru_pkg::MODE_CAS,  10'd0, 32'd4, 32'hFFFF_FFFF);
		send_request(amru_pkg::MODE_AND,  10'd1023, 32'h0F0F_F0F0, 32'd0);
		send_request(amru_pkg::MODE_OR,   10'd1023, 32'h8000_0001, 32'd0);
		send_request(amru_pkg::MODE_XOR,  10'd1023, 32'hFFFF_FFFF, 32'd0);
		// unused modes only read
		send_request(4'd13, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(4'd15, 10'd1023, 32'd0, 32'd0);
		// float special cases: nan, opposite infinities, zero sums, overflow
		send_request(amru_pkg::MODE_EXCH, 10'd2, 32'h7F80_0001, 32'd0);
		send_request(amru_pkg::MODE_FADD, 10'd2, 32'h3F80_0000, 32'd0);
		send_request(amru_pkg::MODE_EXCH, 10'd2, 32'h7F80_0000, 32'd0);
		send_request(amru_pkg::MODE_FADD, 10'd2, 32'hFF80_0000, 32'd0);
		send_request(amru_pkg::MODE_EXCH, 10'd2, 32'h8000_0000, 32'd0);
		send_request(amru_pkg::MODE_FADD, 10'd2, 32'h8000_0000, 32'd0);
		send_request(amru_pkg::MODE_EXCH, 10'd2, 32'h7F7F_FFFF, 32'd0);
		send_request(amru_pkg::MODE_FADD, 10'd2, 32'h7F7F_FFFF, 32'd0);
		send_request(amru_pkg::MODE_FADD, 10'd2, 32'h0000_0001, 32'd0);
	endtask

	// float operands near the old word to exercise cancellation and rounding
	function automatic logic [31:0] float_operand(logic [31:0] old);
		case ($urandom_range(5, 0))
			0: return old ^ 32'h8000_0000 ^ ($urandom_range(7, 0));
			1: return $urandom & 32'h807F_FFFF;
			2: return {$urandom_range(1, 0) == 1, 8'hFF, 23'($urandom_range(1, 0) << 22)};
			3: return {~old[31], old[30:23], 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random(int n);
		logic [3:0]  mode;
		logic [9:0]  addr;
		logic [31:0] opnd, old;
		int          burst;
		while (n > 0) begin
			burst = $urandom_range(12, 1);
			while (burst > 0 && n > 0) begin
				mode = 4'($urandom_range(15, 0));
				// a few hot addresses so updates chain on the same word
				addr = ($urandom_range(3, 0) == 0) ? 10'($urandom) : 10'($urandom_range(3, 0));
				old  = shadow_mem[addr];
				case ($urandom_range(3, 0))
					0: opnd = old;
					1: opnd = old + $urandom_range(2, 0) - 1;
					default: opnd = $urandom;
				endcase
				if (mode == amru_pkg::MODE_FADD) opnd = float_operand(old);
				send_request(mode, addr, opnd, $urandom);
				burst--;
				n--;
			end
			if ($urandom_range(2, 0) == 0) pause_sender($urandom_range(6, 1));
		end
	endtask

	// receiver stalls on its own pattern, with stall-free stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(63, 0) == 0) stall_on <= ~stall_on;
			m_tready <= stall_on ? ($urandom_range(2, 0) == 0) : 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (old_word_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				logic [31:0] want;
				bit          known;
				want  = old_word_q.pop_front();
				known = known_q.pop_front();
				if (known && m_tdata !== want) begin
					$display("%0t: old_value mismatch, expected %h, actual %h",
						$time, want, m_tdata);
					errors++;
				end
			end
			got_count++;
		end
	end

	// watchdog on cycles without any accepted item or returned result
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (!test_done) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("atomic_memory_rmw_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		sent_count = 0;
		test_done = 1'b0;
		for (int i = 0; i < amru_pkg::MEM_WORDS_DEF; i++) begin
			written[i] = 1'b0;
			shadow_mem[i] = 32'd0;
		end
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// words touched by the directed part are written before being read
		send_request(amru_pkg::MODE_EXCH, 10'd1023, 32'h1234_5678, 32'd0);
		written[1023] = 1'b1;
		test_directed();
		wait_drained();
		test_seed_memory();
		test_random(600);
		wait_drained();
		repeat (60) @(negedge clk);
		test_done = 1'b1;

		$display("covered %0d requests over all modes, float corner cases and every word",
			sent_count);
		$display("returned %0d results under random stalls, %0d mismatches", got_count, errors);
		if (errors == 0 && old_word_q.size() == 0)
			$display("atomic_memory_rmw_unit test passed");
		else
			$display("atomic_memory_rmw_unit test failed");
		$finish;
	end

endmodule
